@@ design/csim_pkg.sv @@
// Shared types, constants and codes of the current spike interval monitor.
package csim_pkg;

	localparam int HISTORY_DEPTH = 10;
	localparam int TOTAL_W       = 16 + $clog2(HISTORY_DEPTH);
	localparam int FRAC_W        = 12;
	localparam int NUM_W         = 32 + FRAC_W;
	localparam int DEN_W         = 20;
	localparam int CNT_W         = $clog2(NUM_W + 1);
	localparam int IDX_W         = 3;
	localparam int CFG_W         = 32;

	localparam int MEAN_SHIFT  = TOTAL_W - 1 + $clog2(HISTORY_DEPTH);
	localparam int MEAN_PROD_W = TOTAL_W + MEAN_SHIFT + 1;
	localparam logic [MEAN_SHIFT:0] MEAN_RECIP = (MEAN_SHIFT + 1)'(
		((longint'(1) << MEAN_SHIFT) + longint'(HISTORY_DEPTH) - 1) / longint'(HISTORY_DEPTH));

	localparam logic [DEN_W-1:0] COUNT_MAX = '1;

	localparam logic signed [15:0] RST_THRESHOLD = 16'sd21299;
	localparam logic               RST_MODE      = 1'b1;
	localparam logic [31:0]        RST_MWIN      = 32'd500000;
	localparam logic [31:0]        RST_CWIN      = 32'd1000000;
	localparam logic [7:0]         RST_TARGET    = 8'd3;
	localparam logic [19:0]        RST_NOMINAL   = 20'd9000;

	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;
	localparam logic MODE_CHECK   = 1'b0;
	localparam logic MODE_MEASURE = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_MODE      = 3'd1,
		REG_MWIN      = 3'd2,
		REG_CWIN      = 3'd3,
		REG_TARGET    = 3'd4,
		REG_NOMINAL   = 3'd5
	} csim_reg_t;

	typedef enum logic [1:0] {
		DIV_INTERVAL,
		DIV_ERROR
	} csim_div_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INT_GO,
		ST_INT_WAIT,
		ST_ERR_GO,
		ST_ERR_WAIT,
		ST_MEAN,
		ST_EMIT
	} csim_state_t;

	typedef struct packed {
		logic          accept;
		logic          div_start;
		csim_div_sel_t div_sel;
		logic          int_load;
		logic          err_push;
		logic          mean_load;
		logic          out_load;
	} csim_cmd_t;

	typedef struct packed {
		logic close;
		logic need_div;
		logic div_busy;
		logic div_done;
	} csim_sts_t;

endpackage

@@ design/csim_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module csim_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [csim_pkg::NUM_W-1:0] num,
	input  logic [csim_pkg::DEN_W-1:0] den,
	output logic                      busy,
	output logic                      done,
	output logic [csim_pkg::NUM_W-1:0] quo
);
	import csim_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;

endmodule

@@ design/csim_dp.sv @@
// Datapath: configuration, window tracking, divider operands, error history and result.
module csim_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [csim_pkg::IDX_W-1:0] cfg_index,
	input  logic [csim_pkg::CFG_W-1:0] cfg_data,
	input  logic                       action,
	input  logic signed [15:0]         sample,
	input  logic [31:0]                stamp_us,
	input  csim_pkg::csim_cmd_t        cmd,
	output csim_pkg::csim_sts_t        sts,
	output logic                       status,
	output logic [19:0]                spike_count,
	output logic [31:0]                interval_us,
	output logic signed [15:0]         error_now,
	output logic signed [15:0]         error_mean
);
	import csim_pkg::*;

	logic signed [15:0] thresh_q;
	logic               mode_q;
	logic [31:0]        mwin_q;
	logic [31:0]        cwin_q;
	logic [7:0]         target_q;
	logic [19:0]        nominal_q;

	logic [31:0]      start_q;
	logic             open_q;
	logic             in_spike_q;
	logic [DEN_W-1:0] counter_q;

	logic [31:0]        elapsed_q;
	logic [31:0]        interval_q;
	logic signed [15:0] err_q;
	logic signed [15:0] mean_q;

	logic signed [15:0]        hist_q [HISTORY_DEPTH];
	logic signed [TOTAL_W-1:0] total_q;

	logic               status_q;
	logic [19:0]        count_out_q;
	logic [31:0]        interval_out_q;
	logic signed [15:0] err_out_q;
	logic signed [15:0] mean_out_q;

	logic                   spike_hi;
	logic [31:0]            elapsed;
	logic [DEN_W-1:0]       counter_n;
	logic                   err_neg;
	logic [31:0]            err_mag;
	logic                   total_neg;
	logic [TOTAL_W-1:0]     total_mag;
	logic [MEAN_PROD_W-1:0] mean_prod;
	logic [15:0]            mean_mag;
	logic [NUM_W-1:0]       div_num;
	logic [DEN_W-1:0]       div_den;
	logic                   div_busy;
	logic                   div_done;
	logic [NUM_W-1:0]       quo;
	logic signed [15:0]     err_val;
	logic signed [15:0]     mean_val;

	always_comb begin
		spike_hi  = sample > thresh_q;
		elapsed   = stamp_us - start_q;
		counter_n = counter_q;
		if (!spike_hi && in_spike_q && counter_q != COUNT_MAX) begin
			counter_n = counter_q + 1'b1;
		end
		sts.close = (action == ACT_SAMPLE) && open_q && !spike_hi &&
			((mode_q == MODE_MEASURE) ? (elapsed > mwin_q) :
			 (counter_n >= DEN_W'(target_q) || elapsed > cwin_q));
		sts.need_div = (mode_q == MODE_MEASURE) && counter_n != '0;
		sts.div_busy = div_busy;
		sts.div_done = div_done;
	end

	always_comb begin
		err_neg   = interval_q > 32'(nominal_q);
		err_mag   = err_neg ? interval_q - 32'(nominal_q) : 32'(nominal_q) - interval_q;
		total_neg = total_q[TOTAL_W-1];
		total_mag = total_neg ? TOTAL_W'(-total_q) : TOTAL_W'(total_q);
		mean_prod = MEAN_PROD_W'(total_mag) * MEAN_PROD_W'(MEAN_RECIP);
		mean_mag  = mean_prod[MEAN_SHIFT +: 16];
		unique case (cmd.div_sel)
			DIV_INTERVAL: begin
				div_num = NUM_W'(elapsed_q);
				div_den = counter_q;
			end
			DIV_ERROR: begin
				div_num = {err_mag, {FRAC_W{1'b0}}};
				div_den = nominal_q;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	always_comb begin
		if (nominal_q == '0) begin
			err_val = (interval_q == '0) ? 16'sh0000 : 16'sh8000;
		end else if (err_neg) begin
			err_val = (quo > NUM_W'(32768)) ? 16'sh8000 : 16'(~quo[15:0] + 16'd1);
		end else begin
			err_val = (quo > NUM_W'(32767)) ? 16'sh7FFF : quo[15:0];
		end
		mean_val = total_neg ? 16'(~mean_mag + 16'd1) : mean_mag;
	end

	csim_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= RST_THRESHOLD;
			mode_q    <= RST_MODE;
			mwin_q    <= RST_MWIN;
			cwin_q    <= RST_CWIN;
			target_q  <= RST_TARGET;
			nominal_q <= RST_NOMINAL;
		end else if (cfg_we) begin
			unique case (csim_reg_t'(cfg_index))
				REG_THRESHOLD: thresh_q  <= cfg_data[15:0];
				REG_MODE:      mode_q    <= cfg_data[0];
				REG_MWIN:      mwin_q    <= cfg_data[31:0];
				REG_CWIN:      cwin_q    <= cfg_data[31:0];
				REG_TARGET:    target_q  <= cfg_data[7:0];
				REG_NOMINAL:   nominal_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			open_q     <= 1'b0;
			in_spike_q <= 1'b0;
			counter_q  <= '0;
		end else if (cmd.accept) begin
			if (action == ACT_START) begin
				start_q    <= stamp_us;
				open_q     <= 1'b1;
				in_spike_q <= 1'b0;
				counter_q  <= '0;
			end else if (open_q) begin
				in_spike_q <= spike_hi;
				counter_q  <= counter_n;
				if (sts.close) begin
					open_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			total_q <= '0;
			mean_q  <= '0;
		end else begin
			if (cmd.err_push) begin
				for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
					hist_q[i] <= hist_q[i+1];
				end
				hist_q[HISTORY_DEPTH-1] <= err_val;
				total_q <= total_q - TOTAL_W'(hist_q[0]) + TOTAL_W'(err_val);
			end
			if (cmd.mean_load) begin
				mean_q <= mean_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.close) begin
			elapsed_q  <= elapsed;
			interval_q <= '0;
			err_q      <= '0;
		end else begin
			if (cmd.int_load) begin
				interval_q <= quo[31:0];
			end
			if (cmd.err_push) begin
				err_q <= err_val;
			end
		end
		if (cmd.out_load) begin
			status_q       <= counter_q == '0;
			count_out_q    <= counter_q;
			interval_out_q <= interval_q;
			err_out_q      <= err_q;
			mean_out_q     <= mean_q;
		end
	end

	assign status      = status_q;
	assign spike_count = count_out_q;
	assign interval_us = interval_out_q;
	assign error_now   = err_out_q;
	assign error_mean  = mean_out_q;

endmodule

@@ design/csim_ctrl.sv @@
// Controller: handshakes and the sequence of divisions at a window close.
module csim_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  csim_pkg::csim_sts_t sts,
	output csim_pkg::csim_cmd_t cmd
);
	import csim_pkg::*;

	csim_state_t state_q;
	csim_state_t state_n;
	logic        out_valid_q;
	logic        out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		state_n  = state_q;
		in_stall = 1'b1;
		cmd      = '{default: '0, div_sel: DIV_INTERVAL};
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && sts.close) begin
					state_n = sts.need_div ? ST_INT_GO : ST_EMIT;
				end
			end
			ST_INT_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_INTERVAL;
				state_n       = ST_INT_WAIT;
			end
			ST_INT_WAIT: begin
				if (sts.div_done) begin
					cmd.int_load = 1'b1;
					state_n      = ST_ERR_GO;
				end
			end
			ST_ERR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_ERROR;
				state_n       = ST_ERR_WAIT;
			end
			ST_ERR_WAIT: begin
				if (sts.div_done) begin
					cmd.err_push = 1'b1;
					state_n      = ST_MEAN;
				end
			end
			ST_MEAN: begin
				cmd.mean_load = 1'b1;
				state_n       = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/current_spike_interval_monitor_core.sv @@
// Top level of the current spike interval monitor: controller, datapath and checks.
// A sample or start transaction that closes no window leaves the controller idle; one per cycle is accepted while idle.
// A closing sample in check mode, or with no spikes, skips the divisions and goes straight to the emit state.
// A measure-mode close runs two 44-step divisions on the shared divider.
// Input is stalled from a closing transaction until its result is in the output register.
// Reset clears window state, history and mean; configuration registers return to their default values.
module current_spike_interval_monitor_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [csim_pkg::IDX_W-1:0] cfg_index,
	input  logic [csim_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic signed [15:0]         sample,
	input  logic [31:0]                stamp_us,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic [19:0]                spike_count,
	output logic [31:0]                interval_us,
	output logic signed [15:0]         error_now,
	output logic signed [15:0]         error_mean
);
	import csim_pkg::*;

	csim_cmd_t cmd;
	csim_sts_t sts;

	csim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	csim_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.sample      (sample),
		.stamp_us    (stamp_us),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.spike_count (spike_count),
		.interval_us (interval_us),
		.error_now   (error_now),
		.error_mean  (error_mean)
	);

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> in_stall)
		else $error("input taken while divider busy");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("result shown without load");

	a_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == (spike_count == '0)))
		else $error("status disagrees with spike count");

endmodule

@@ tb/testbench.sv @@
// Testbench of the current spike interval monitor: directed and random windows against a predictor.
`timescale 1ns / 100ps

module testbench;
	import csim_pkg::*;

	localparam int RANDOM_ITEMS  = 750;
	localparam int SETTLE_CYCLES = 160;
	localparam int TIMEOUT_NS    = 12_000_000;

	typedef struct packed {
		logic               status;
		logic [19:0]        count;
		logic [31:0]        interval;
		logic signed [15:0] err_now;
		logic signed [15:0] err_mean;
	} window_report_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_we      = 1'b0;
	logic [IDX_W-1:0]   cfg_index   = '0;
	logic [CFG_W-1:0]   cfg_data    = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic               action      = ACT_START;
	logic signed [15:0] sample      = '0;
	logic [31:0]        stamp_us    = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic               status;
	logic [19:0]        spike_count;
	logic [31:0]        interval_us;
	logic signed [15:0] error_now;
	logic signed [15:0] error_mean;

	logic signed [15:0] thr_cfg     = RST_THRESHOLD;
	logic               mode_cfg    = RST_MODE;
	logic [31:0]        mwin_cfg    = RST_MWIN;
	logic [31:0]        cwin_cfg    = RST_CWIN;
	logic [7:0]         target_cfg  = RST_TARGET;
	logic [19:0]        nominal_cfg = RST_NOMINAL;

	logic [31:0]        win_start_m = '0;
	bit                 win_open_m  = 1'b0;
	bit                 in_spike_m  = 1'b0;
	logic [19:0]        count_m     = '0;
	logic signed [15:0] err_hist [HISTORY_DEPTH] = '{default: '0};
	int                 err_sum     = 0;

	window_report_t window_reports [$];
	window_report_t seen_report;
	window_report_t want_report;

	int n_items    = 0;
	int n_errors   = 0;
	int burst_left = 0;

	logic [6:0] stall_tick = '0;
	logic [1:0] stall_mode = '0;

	current_spike_interval_monitor_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.sample      (sample),
		.stamp_us    (stamp_us),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.spike_count (spike_count),
		.interval_us (interval_us),
		.error_now   (error_now),
		.error_mean  (error_mean)
	);

	always #6 clk = ~clk;

	// advance the window tracking by one accepted transaction; queue a report on close
	function automatic bit advance_window(input logic act, input logic signed [15:0] smp,
			input logic [31:0] stamp);
		logic [31:0]    elapsed;
		bit             closing;
		longint         diff;
		longint         q;
		window_report_t rpt;
		rpt = '0;
		if (act == ACT_START) begin
			win_start_m = stamp;
			win_open_m  = 1'b1;
			in_spike_m  = 1'b0;
			count_m     = '0;
			return 1'b1;
		end
		if (!win_open_m)
			return 1'b0;
		if (smp > thr_cfg) begin
			in_spike_m = 1'b1;
		end else if (in_spike_m) begin
			in_spike_m = 1'b0;
			if (count_m != COUNT_MAX)
				count_m = count_m + 20'd1;
		end
		if (in_spike_m)
			return 1'b1;
		elapsed = stamp - win_start_m;
		if (mode_cfg == MODE_MEASURE)
			closing = elapsed > mwin_cfg;
		else
			closing = (count_m >= {12'd0, target_cfg}) || (elapsed > cwin_cfg);
		if (!closing)
			return 1'b1;
		win_open_m = 1'b0;
		if (mode_cfg == MODE_MEASURE && count_m != '0) begin
			rpt.interval = elapsed / {12'd0, count_m};
			if (nominal_cfg == '0) begin
				rpt.err_now = (rpt.interval == '0) ? 16'sd0 : -16'sd32768;
			end else begin
				diff = longint'(nominal_cfg) - longint'(rpt.interval);
				q = (diff * 4096) / longint'(nominal_cfg);
				if (q > 32767)
					rpt.err_now = 16'sd32767;
				else if (q < -32768)
					rpt.err_now = -16'sd32768;
				else
					rpt.err_now = 16'(q);
			end
			err_sum = err_sum - int'(err_hist[0]);
			for (int i = 0; i < HISTORY_DEPTH - 1; i++)
				err_hist[i] = err_hist[i + 1];
			err_hist[HISTORY_DEPTH - 1] = rpt.err_now;
			err_sum = err_sum + int'(rpt.err_now);
		end
		rpt.status   = (count_m == '0);
		rpt.count    = count_m;
		rpt.err_mean = 16'(err_sum / HISTORY_DEPTH);
		window_reports.push_back(rpt);
		return 1'b1;
	endfunction

	task automatic send_item(input logic act, input logic signed [15:0] smp,
			input logic [31:0] stamp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action   <= act;
		sample   <= smp;
		stamp_us <= stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (advance_window(act, smp, stamp))
			n_items++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (window_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input csim_reg_t idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic set_config(input logic signed [15:0] thr, input logic mode,
			input logic [31:0] mwin, input logic [31:0] cwin, input logic [7:0] target,
			input logic [19:0] nominal);
		write_reg(REG_THRESHOLD, 32'(thr));
		write_reg(REG_MODE, {31'd0, mode});
		write_reg(REG_MWIN, mwin);
		write_reg(REG_CWIN, cwin);
		write_reg(REG_TARGET, {24'd0, target});
		write_reg(REG_NOMINAL, {12'd0, nominal});
		cfg_we <= 1'b0;
		thr_cfg     = thr;
		mode_cfg    = mode;
		mwin_cfg    = mwin;
		cwin_cfg    = cwin;
		target_cfg  = target;
		nominal_cfg = nominal;
		@(posedge clk);
	endtask

	// reset defaults: sample with no window, restart of an open window, saturated error
	task automatic test_default_window();
		send_item(ACT_SAMPLE, 16'sd32767, 32'd50);
		send_item(ACT_START, 16'sd0, 32'd100);
		send_item(ACT_SAMPLE, 16'sd32767, 32'd200);
		send_item(ACT_START, -16'sd1, 32'd1000);
		send_item(ACT_SAMPLE, 16'sd32767, 32'd1100);
		send_item(ACT_SAMPLE, -16'sd32768, 32'd600000);
		settle();
	endtask

	task automatic test_threshold_extremes();
		set_config(16'sd32767, MODE_MEASURE, 32'd1000, RST_CWIN, RST_TARGET, 20'd1500);
		send_item(ACT_START, 16'sd0, 32'hFFFF_FF00);
		send_item(ACT_SAMPLE, 16'sd32767, 32'h0000_0400);
		settle();
		set_config(-16'sd32768, MODE_MEASURE, 32'd1000, RST_CWIN, RST_TARGET, 20'd1500);
		send_item(ACT_START, 16'sd0, 32'd5000);
		send_item(ACT_SAMPLE, -16'sd32767, 32'd5100);
		send_item(ACT_SAMPLE, -16'sd32768, 32'd5600);
		send_item(ACT_SAMPLE, -16'sd32768, 32'd6500);
		settle();
	endtask

	// check mode: close on peak target, on timeout, and at once with a zero target
	task automatic test_check_mode();
		set_config(16'sd0, MODE_CHECK, 32'd1000, 32'd5000, 8'd2, RST_NOMINAL);
		send_item(ACT_START, 16'sd0, 32'd0);
		send_item(ACT_SAMPLE, 16'sd1, 32'd10);
		send_item(ACT_SAMPLE, 16'sd0, 32'd20);
		send_item(ACT_SAMPLE, 16'sd100, 32'd30);
		send_item(ACT_SAMPLE, -16'sd5, 32'd40);
		send_item(ACT_START, 16'sd0, 32'd7);
		send_item(ACT_SAMPLE, -16'sd100, 32'd6000);
		settle();
		set_config(16'sd0, MODE_CHECK, 32'd1000, 32'hFFFF_FFFF, 8'd0, RST_NOMINAL);
		send_item(ACT_START, 16'sd0, 32'd123);
		send_item(ACT_SAMPLE, 16'sd0, 32'd123);
		settle();
	endtask

	// zero interval, zero nominal and timestamp wrap
	task automatic test_interval_corners();
		set_config(16'sd0, MODE_MEASURE, 32'd0, RST_CWIN, RST_TARGET, 20'd0);
		send_item(ACT_START, 16'sd0, 32'hFFFF_FFFF);
		send_item(ACT_SAMPLE, 16'sd5, 32'hFFFF_FFFF);
		send_item(ACT_SAMPLE, 16'sd0, 32'hFFFF_FFFF);
		send_item(ACT_SAMPLE, 16'sd5, 32'hFFFF_FFFF);
		send_item(ACT_SAMPLE, 16'sd0, 32'h0000_0000);
		send_item(ACT_START, 16'sd0, 32'd10);
		send_item(ACT_SAMPLE, 16'sd5, 32'd11);
		send_item(ACT_SAMPLE, 16'sd0, 32'd12);
		settle();
		set_config(16'sd0, MODE_MEASURE, 32'd0, RST_CWIN, RST_TARGET, 20'd7);
		send_item(ACT_START, 16'sd0, 32'd10);
		send_item(ACT_SAMPLE, 16'sd5, 32'd10);
		send_item(ACT_SAMPLE, 16'sd0, 32'd10);
		send_item(ACT_SAMPLE, 16'sd5, 32'd10);
		send_item(ACT_SAMPLE, 16'sd0, 32'd11);
		settle();
	endtask

	task automatic test_random_windows();
		int                 ph;
		int                 phase_items;
		int                 len;
		int                 base_items;
		int                 t;
		bit                 hi;
		logic signed [15:0] thr;
		logic signed [15:0] smp;
		logic               mode;
		logic [31:0]        mwin;
		logic [31:0]        cwin;
		logic [31:0]        win;
		logic [31:0]        stamp;
		logic [7:0]         target;
		logic [19:0]        nominal;
		base_items = n_items;
		ph = 0;
		while (n_items - base_items < RANDOM_ITEMS && ph < 100) begin
			thr     = 16'(int'($urandom_range(0, 40000)) - 20000);
			mode    = 1'($urandom_range(0, 1));
			mwin    = $urandom_range(0, 1 << $urandom_range(4, 20));
			cwin    = $urandom_range(0, 1 << $urandom_range(4, 20));
			target  = 8'($urandom_range(1, 6));
			nominal = 20'($urandom_range(1, 1 << $urandom_range(1, 19)));
			unique case (ph % 12)
				0: thr = -16'sd32768;
				1: thr = 16'sd32767;
				2: begin mwin = '0; mode = MODE_MEASURE; end
				3: begin mwin = '1; mode = MODE_MEASURE; end
				4: begin cwin = '0; mode = MODE_CHECK; end
				5: begin cwin = '1; mode = MODE_CHECK; end
				6: begin target = 8'd255; mode = MODE_CHECK; end
				7: begin target = 8'd1; mode = MODE_CHECK; end
				8: begin nominal = 20'd1; mode = MODE_MEASURE; end
				9: begin nominal = '1; mode = MODE_MEASURE; end
				10: begin target = 8'd0; mode = MODE_CHECK; end
				default: begin nominal = '0; mode = MODE_MEASURE; end
			endcase
			set_config(thr, mode, mwin, cwin, target, nominal);
			win = (mode == MODE_MEASURE) ? mwin : cwin;
			phase_items = 0;
			while (phase_items < 55) begin
				if ($urandom_range(0, 9) < 2) begin
					send_item(1'($urandom_range(0, 1)), 16'($urandom), $urandom);
					phase_items++;
				end else begin
					stamp = $urandom;
					send_item(ACT_START, 16'($urandom), stamp);
					phase_items++;
					len = $urandom_range(4, 40);
					for (int k = 0; k < len && win_open_m; k++) begin
						stamp += ($urandom_range(0, 15) == 0) ? $urandom :
							$urandom_range(0, (win >> 3) + 1);
						t  = int'(thr_cfg);
						hi = in_spike_m ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 2) == 0);
						if (hi && t < 32767)
							smp = ($urandom_range(0, 7) == 0) ? 16'(t + 1) :
								16'(t + 1 + int'($urandom_range(0, 32766 - t)));
						else
							smp = ($urandom_range(0, 7) == 0) ? 16'(t) :
								16'(-32768 + int'($urandom_range(0, t + 32768)));
						send_item(ACT_SAMPLE, smp, stamp);
						phase_items++;
					end
				end
			end
			settle();
			ph++;
		end
	endtask

	always @(posedge clk) begin
		stall_tick <= stall_tick + 7'd1;
		if (stall_tick == '0)
			stall_mode <= 2'($urandom_range(0, 3));
		unique case (stall_mode)
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= 1'($urandom_range(0, 1));
			2'd2: out_stall <= ($urandom_range(0, 7) == 0);
			default: out_stall <= stall_tick[4];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_report = {status, spike_count, interval_us, error_now, error_mean};
			if (window_reports.size() == 0) begin
				if (n_errors < 10)
					$display("%0t: unexpected transaction: status %0d count %0d interval %0d err %0d mean %0d",
						$realtime, status, spike_count, interval_us, error_now, error_mean);
				n_errors++;
			end else begin
				want_report = window_reports.pop_front();
				if (seen_report.status !== want_report.status
						|| seen_report.count !== want_report.count
						|| seen_report.interval !== want_report.interval
						|| seen_report.err_now !== want_report.err_now
						|| seen_report.err_mean !== want_report.err_mean) begin
					if (n_errors < 10)
						$display("%0t: mismatch: want %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
							$realtime, want_report.status, want_report.count,
							want_report.interval, want_report.err_now, want_report.err_mean,
							seen_report.status, seen_report.count, seen_report.interval,
							seen_report.err_now, seen_report.err_mean);
					n_errors++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_threshold_extremes();
		test_check_mode();
		test_interval_corners();
		test_random_windows();
		settle();
		if (n_errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("testbench: errors");
		$finish;
	end

endmodule

@@ current_spike_interval_monitor_core.f @@
design/csim_pkg.sv
design/csim_div.sv
design/csim_dp.sv
design/csim_ctrl.sv
design/current_spike_interval_monitor_core.sv
tb/testbench.sv
